// File: rtl/core/dense_layer_forward_macros.svh
`ifndef DENSE_LAYER_FORWARD_MACROS_SVH
`define DENSE_LAYER_FORWARD_MACROS_SVH

// Condition must never hold outside reset
`define DLF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define DLF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define DLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dlf_pkg.sv
package dlf_pkg;

    // Default geometry
    localparam int DEF_OUTPUTS = 16;
    localparam int DEF_INPUTS  = 64;

    // Field widths
    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 10;
    localparam int VALUE_W     = 16;
    localparam int OUT_INDEX_W = 4;
    localparam int ACC_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 1;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ELEM   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_EN  = 1'd1;

    // Saturating 32-bit add
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

// File: rtl/core/dense_layer_forward.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_mode, s_index, s_value, s_last
// m_        out        m_valid/m_ready    m_out_index, m_out_value, m_out_last
// cfg_      in         cfg_wr_en          cfg_index, cfg_data
//
// Weight and bias write items leave s_ready high. An element item drops s_ready after its
// accept: one multiply-accumulate unit walks the accumulators, one neuron per cycle, the
// two pipeline stages drain and the sequencer returns to idle, so a new element is taken
// only once the last one is through. A last element then emits OUTPUTS items, each
// through the states EMIT_RD, EMIT_LD and EMIT_SEND; a low m_ready stalls the emit walk.
// Reset clears accumulators through per-entry valid bits, so no clearing pass runs.
module dense_layer_forward #(
    parameter int OUTPUTS = dlf_pkg::DEF_OUTPUTS,
    parameter int INPUTS  = dlf_pkg::DEF_INPUTS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [dlf_pkg::MODE_W-1:0]             s_mode,
    input  logic [dlf_pkg::INDEX_W-1:0]            s_index,
    input  logic signed [dlf_pkg::VALUE_W-1:0]     s_value,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [dlf_pkg::OUT_INDEX_W-1:0]        m_out_index,
    output logic signed [dlf_pkg::ACC_W-1:0]       m_out_value,
    output logic                                   m_out_last
);
    import dlf_pkg::*;

    `include "dense_layer_forward_macros.svh"

    localparam int WDEPTH = OUTPUTS * INPUTS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int KW     = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
    localparam int KCW    = $clog2(OUTPUTS + 1);
    localparam int CW     = $clog2(INPUTS + 1);
    localparam logic [KCW-1:0] OUTPUTS_C = KCW'(OUTPUTS);
    localparam logic [KCW-1:0] LAST_K_C  = KCW'(OUTPUTS - 1);
    localparam logic [CW-1:0]  INPUTS_C  = CW'(INPUTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_SEND
    } state_t;

    // Storage
    logic signed [VALUE_W-1:0] weight_mem [WDEPTH];
    logic signed [VALUE_W-1:0] bias_mem   [OUTPUTS];
    logic signed [ACC_W-1:0]   acc_mem    [OUTPUTS];

    // Control registers
    state_t               state_reg, state_next;
    logic [KCW-1:0]       k_reg, k_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 s1_vld_reg, s1_vld_next;
    logic                 s2_vld_reg, s2_vld_next;
    logic [OUTPUTS-1:0]   acc_vld_reg, acc_vld_next;
    logic                 bias_en_reg, acc_en_reg;
    logic                 m_valid_reg, m_valid_next;

    // Per-item and datapath registers
    logic signed [VALUE_W-1:0] val_reg;
    logic                      first_reg;
    logic                      mac_reg;
    logic                      last_reg;
    logic [WAW-1:0]            wbase_reg;
    logic signed [VALUE_W-1:0] w_rd_reg;
    logic signed [VALUE_W-1:0] b_rd_reg;
    logic signed [ACC_W-1:0]   a_rd_reg;
    logic                      a_rdv_reg;
    logic [KW-1:0]             s1_k_reg;
    logic [KW-1:0]             s2_k_reg;
    logic signed [ACC_W-1:0]   s2_init_reg;
    logic signed [ACC_W-1:0]   s2_prod_reg;
    logic [OUT_INDEX_W-1:0]    m_index_reg;
    logic signed [ACC_W-1:0]   m_value_reg;
    logic                      m_last_reg;

    logic                      s_acc;
    logic                      issuing;
    logic [KW-1:0]             k_idx;
    logic [WAW-1:0]            w_raddr;
    logic signed [ACC_W-1:0]   a_cur;
    logic signed [ACC_W-1:0]   b32;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   init_val;
    logic signed [ACC_W-1:0]   acc_sum;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_acc       = s_valid && s_ready;
    assign issuing     = (state_reg == ST_MAC) && (k_reg < OUTPUTS_C);
    assign k_idx       = k_reg[KW-1:0];
    assign w_raddr     = wbase_reg + WAW'(k_idx);
    assign m_valid     = m_valid_reg;
    assign m_out_index = m_index_reg;
    assign m_out_value = m_value_reg;
    assign m_out_last  = m_last_reg;

    // Stage one: product and start-of-vector initial value
    assign a_cur = a_rdv_reg ? a_rd_reg : '0;
    assign b32   = {{8{b_rd_reg[VALUE_W-1]}}, b_rd_reg, 8'h00};
    assign prod  = w_rd_reg * val_reg;

    always_comb begin
        init_val = a_cur;
        if (first_reg) begin
            if (bias_en_reg) begin
                init_val = acc_en_reg ? sat_add(a_cur, b32) : b32;
            end else if (!acc_en_reg) begin
                init_val = '0;
            end
        end
    end

    // Stage two: saturating accumulate
    assign acc_sum = sat_add(s2_init_reg, s2_prod_reg);

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        count_next   = count_reg;
        s1_vld_next  = 1'b0;
        s2_vld_next  = s1_vld_reg;
        acc_vld_next = acc_vld_reg;
        m_valid_next = m_valid_reg;
        if (s2_vld_reg) begin
            acc_vld_next[s2_k_reg] = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_mode == MODE_ELEM) begin
                    k_next     = '0;
                    state_next = ST_MAC;
                    if (s_last) begin
                        count_next = '0;
                    end else if (count_reg < INPUTS_C) begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_MAC: begin
                if (issuing) begin
                    k_next      = k_reg + KCW'(1);
                    s1_vld_next = 1'b1;
                end else if (!s1_vld_reg && !s2_vld_reg) begin
                    k_next     = '0;
                    state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                m_valid_next = 1'b1;
                state_next   = ST_EMIT_SEND;
            end
            ST_EMIT_SEND: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (k_reg == LAST_K_C) begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + KCW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state, control and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            count_reg   <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            acc_vld_reg <= '0;
            m_valid_reg <= 1'b0;
            bias_en_reg <= 1'b1;
            acc_en_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            count_reg   <= count_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            acc_vld_reg <= acc_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BIAS_EN: bias_en_reg <= cfg_data[0];
                    CFG_ACC_EN:  acc_en_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Latch the element item and advance the datapath
    always_ff @(posedge aclk) begin
        if (s_acc && s_mode == MODE_ELEM) begin
            val_reg   <= s_value;
            first_reg <= (count_reg == '0);
            mac_reg   <= (s_value != '0) && (count_reg < INPUTS_C);
            last_reg  <= s_last;
            wbase_reg <= WAW'(32'(count_reg) * 32'(OUTPUTS));
        end
        s1_k_reg    <= k_idx;
        s2_k_reg    <= s1_k_reg;
        s2_init_reg <= init_val;
        s2_prod_reg <= mac_reg ? prod : '0;
        if (state_reg == ST_EMIT_LD) begin
            m_index_reg <= OUT_INDEX_W'(k_reg);
            m_value_reg <= a_cur;
            m_last_reg  <= (k_reg == LAST_K_C);
        end
    end

    // Weight store
    always_ff @(posedge aclk) begin
        if (s_acc && s_mode == MODE_WEIGHT && 32'(s_index) < 32'(WDEPTH)) begin
            weight_mem[WAW'(s_index)] <= s_value;
        end
        w_rd_reg <= weight_mem[w_raddr];
    end

    // Bias store
    always_ff @(posedge aclk) begin
        if (s_acc && s_mode == MODE_BIAS && 32'(s_index) < 32'(OUTPUTS)) begin
            bias_mem[KW'(s_index)] <= s_value;
        end
        b_rd_reg <= bias_mem[k_idx];
    end

    // Accumulator store
    always_ff @(posedge aclk) begin
        if (s2_vld_reg) begin
            acc_mem[s2_k_reg] <= acc_sum;
        end
        a_rd_reg  <= acc_mem[k_idx];
        a_rdv_reg <= acc_vld_reg[k_idx];
    end

    `DLF_ASSERT_NEVER(a_busy_excl, s_ready && m_valid, "input taken while an output item waits")
    `DLF_ASSERT_IMPL(a_pipe_in_mac, s1_vld_reg || s2_vld_reg, state_reg == ST_MAC,
        "accumulate pipeline active outside the accumulate walk")
    `DLF_ASSERT_NEXT(a_last_frees, m_valid && m_ready && m_out_last, s_ready && !m_valid,
        "block not idle after the final output item")
    `DLF_ASSERT_IMPL(a_last_index, m_valid && m_out_last, k_reg == LAST_K_C,
        "final flag on an output other than the last neuron")

endmodule
